// File: rtl/cba_pkg.sv
// Package: field widths, map word geometry and controller/datapath command and status types.
`timescale 1ns / 1ps
package cba_pkg;

  localparam int START_W        = 10;
  localparam int COUNT_W        = 11;
  localparam int SIZE_W         = 11;
  localparam int OUT_W          = 10;
  localparam int FILE_W         = 11;
  localparam int WORD_W         = 32;
  localparam int WORD_SHIFT     = 5;
  localparam int MAX_BLOCKS_DEF = 1024;

  localparam logic [SIZE_W-1:0] DISK_SIZE_RST = SIZE_W'(1024);

  typedef struct packed {
    logic clear;
    logic load;
    logic sweep_start;
    logic mark;
    logic respond;
    logic grant;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_range;
    logic sweep_done;
    logic hit;
  } dp_sts_t;

endpackage

// File: rtl/cba_if.sv
// Channel interfaces: request, result and configuration write.
`timescale 1ns / 1ps
interface cba_req_if;
  import cba_pkg::*;
  logic               valid;
  logic               ready;
  logic [START_W-1:0] start_block;
  logic [COUNT_W-1:0] block_count;
  modport source (output valid, start_block, block_count, input ready);
  modport sink   (input valid, start_block, block_count, output ready);
endinterface

interface cba_res_if;
  import cba_pkg::*;
  logic             valid;
  logic             ready;
  logic             granted;
  logic [OUT_W-1:0] file_number;
  logic [OUT_W-1:0] end_block;
  modport source (output valid, granted, file_number, end_block, input ready);
  modport sink   (input valid, granted, file_number, end_block, output ready);
endinterface

interface cba_cfg_if;
  import cba_pkg::*;
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: rtl/cba_dpath.sv
// Datapath: used-map memory, range check, word sweep engine, file counter and result register.
`timescale 1ns / 1ps
module cba_dpath #(
  parameter int MAX_BLOCKS = cba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cba_pkg::dp_cmd_t              cmd,
  output cba_pkg::dp_sts_t              sts,
  input  logic [cba_pkg::START_W-1:0]   start_block,
  input  logic [cba_pkg::COUNT_W-1:0]   block_count,
  input  logic                          cfg_we,
  input  logic [cba_pkg::SIZE_W-1:0]    cfg_data,
  output logic                          granted,
  output logic [cba_pkg::OUT_W-1:0]     file_number,
  output logic [cba_pkg::OUT_W-1:0]     end_block
);
  import cba_pkg::*;

  localparam int NUM_WORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int POS_W     = WORD_SHIFT + WADDR_W;
  localparam int SIZE_MAX  = (1 << SIZE_W) - 1;
  localparam logic [SIZE_W-1:0]  MAP_CAP   = SIZE_W'((MAX_BLOCKS > SIZE_MAX) ? SIZE_MAX
                                                                          : MAX_BLOCKS);
  localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(NUM_WORDS - 1);

  logic [WORD_W-1:0] mem [NUM_WORDS];

  logic [SIZE_W-1:0]     disk_size;
  logic [FILE_W-1:0]     file_count;
  logic                  in_range;
  logic [POS_W-1:0]      start_pos;
  logic [POS_W-1:0]      last_pos;
  logic [SIZE_W-1:0]     last_sum;
  logic [WADDR_W-1:0]    clr_word;
  logic [WADDR_W-1:0]    cur_word;
  logic [WADDR_W-1:0]    pend_word;
  logic                  issuing;
  logic                  pend_valid;
  logic                  mark_mode;
  logic                  conflict;
  logic [WORD_W-1:0]     rd_data;

  logic [SIZE_W-1:0]     eff_size;
  logic [SIZE_W-1:0]     room;
  logic                  req_ok;
  logic [SIZE_W-1:0]     sum;
  logic [WADDR_W-1:0]    start_word;
  logic [WADDR_W-1:0]    last_word;
  logic [WORD_SHIFT-1:0] lo;
  logic [WORD_SHIFT-1:0] hi;
  logic [WORD_W-1:0]     mask;
  logic                  hit_word;
  logic                  we;
  logic [WADDR_W-1:0]    waddr;
  logic [WORD_W-1:0]     wdata;

  assign eff_size = (disk_size > MAP_CAP) ? MAP_CAP : disk_size;
  assign room     = eff_size - SIZE_W'(start_block);
  assign req_ok   = (block_count != '0) && (SIZE_W'(start_block) < eff_size) &&
                    (SIZE_W'(block_count) <= room);
  assign sum      = SIZE_W'(start_block) + SIZE_W'(block_count) - SIZE_W'(1);

  assign start_word = start_pos[POS_W-1:WORD_SHIFT];
  assign last_word  = last_pos[POS_W-1:WORD_SHIFT];

  // bits of the word under test that fall inside the run
  always_comb begin
    lo = (pend_word == start_word) ? start_pos[WORD_SHIFT-1:0] : '0;
    hi = (pend_word == last_word)  ? last_pos[WORD_SHIFT-1:0]  : '1;
    for (int j = 0; j < WORD_W; j++) begin
      mask[j] = (WORD_SHIFT'(j) >= lo) && (WORD_SHIFT'(j) <= hi);
    end
  end

  assign hit_word = |(rd_data & mask);

  assign sts.clr_last   = (clr_word == LAST_WORD);
  assign sts.in_range   = in_range;
  assign sts.sweep_done = pend_valid && (pend_word == last_word);
  assign sts.hit        = conflict | (pend_valid & ~mark_mode & hit_word);

  assign we    = cmd.clear | (pend_valid & mark_mode);
  assign waddr = cmd.clear ? clr_word : pend_word;
  assign wdata = cmd.clear ? '0 : (rd_data | mask);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (issuing) begin
      rd_data <= mem[cur_word];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      disk_size  <= DISK_SIZE_RST;
      file_count <= '0;
      clr_word   <= '0;
      issuing    <= 1'b0;
      pend_valid <= 1'b0;
      mark_mode  <= 1'b0;
      conflict   <= 1'b0;
      in_range   <= 1'b0;
    end else begin
      if (cfg_we) begin
        disk_size <= cfg_data;
      end
      if (cmd.clear) begin
        clr_word <= clr_word + WADDR_W'(1);
      end
      if (cmd.load) begin
        in_range <= req_ok;
      end
      if (cmd.respond && cmd.grant) begin
        file_count <= file_count + FILE_W'(1);
      end
      pend_valid <= issuing;
      if (pend_valid && !mark_mode && hit_word) begin
        conflict <= 1'b1;
      end
      if (cmd.sweep_start) begin
        issuing   <= 1'b1;
        mark_mode <= cmd.mark;
        conflict  <= 1'b0;
      end else if (issuing && (cur_word == last_word)) begin
        issuing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_word <= cur_word;
    if (cmd.sweep_start) begin
      cur_word <= start_word;
    end else if (issuing) begin
      cur_word <= cur_word + WADDR_W'(1);
    end
    if (cmd.load) begin
      start_pos <= POS_W'(start_block);
      last_pos  <= POS_W'(sum);
      last_sum  <= sum;
    end
    if (cmd.respond) begin
      granted     <= cmd.grant;
      file_number <= cmd.grant ? file_count[OUT_W-1:0] : '0;
      end_block   <= cmd.grant ? last_sum[OUT_W-1:0] : '0;
    end
  end

endmodule

// File: rtl/cba_ctrl.sv
// Controller: clearing pass, range decision, check and mark sweeps, result hand-off.
`timescale 1ns / 1ps
module cba_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output cba_pkg::dp_cmd_t cmd,
  input  cba_pkg::dp_sts_t sts
);
  import cba_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_CHECK,
    S_MARK,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   ok;
  logic   ok_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    ok_next    = ok;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.in_range) begin
          cmd.sweep_start = 1'b1;
          state_next      = S_CHECK;
        end else begin
          ok_next    = 1'b0;
          state_next = S_DONE;
        end
      end
      S_CHECK: begin
        if (sts.sweep_done) begin
          if (sts.hit) begin
            ok_next    = 1'b0;
            state_next = S_DONE;
          end else begin
            ok_next         = 1'b1;
            cmd.sweep_start = 1'b1;
            cmd.mark        = 1'b1;
            state_next      = S_MARK;
          end
        end
      end
      S_MARK: begin
        if (sts.sweep_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.respond = 1'b1;
          cmd.grant   = ok;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      ok        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      ok    <= ok_next;
      if (cmd.respond) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/contiguous_block_allocator_top.sv
// Top level: contiguous block allocator, controller plus datapath.
//
//   channel  dir  payload                                 transfer when
//   req      in   start_block[9:0], block_count[10:0]     req.valid & req.ready
//   res      out  granted, file_number[9:0], end_block[9:0] res.valid & res.ready
//   cfg      in   data[10:0] (disk_size)                  cfg.valid & cfg.ready
//
// One request at a time. With W the number of 32-block map words the run touches, a grant
// passes through the range check, a check sweep and a mark sweep over the W words, and the
// hand-off; a conflict skips the mark sweep, and a zero count or out-of-range run is refused
// after the range check, with no sweep. req.ready rises with res.valid.
// After reset a clearing pass zeroes every map word with req.ready low; cfg is always
// ready. A stalled result waits in the output register while the next request is taken;
// the one after that waits for res.ready.
`timescale 1ns / 1ps
module contiguous_block_allocator_top #(
  parameter int MAX_BLOCKS = cba_pkg::MAX_BLOCKS_DEF
) (
  input logic      clk,
  input logic      rst,
  cba_req_if.sink  req,
  cba_res_if.source res,
  cba_cfg_if.sink  cfg
);
  import cba_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg.ready = 1'b1;

  cba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  cba_dpath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .start_block (req.start_block),
    .block_count (req.block_count),
    .cfg_we      (cfg.valid),
    .cfg_data    (cfg.data),
    .granted     (res.granted),
    .file_number (res.file_number),
    .end_block   (res.end_block)
  );

endmodule

// File: rtl/cba_checker.sv
// Port-level checker for the allocator top, with its bind.
`timescale 1ns / 1ps
module cba_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      granted,
  input logic [cba_pkg::OUT_W-1:0] file_number,
  input logic [cba_pkg::OUT_W-1:0] end_block
);

  // one request in flight: no transfer in the cycle straight after one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one in flight");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_refusal_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !granted |-> (file_number == '0) && (end_block == '0))
    else $error("refused result carries non-zero fields");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(granted) &&
      $stable(file_number) && $stable(end_block))
    else $error("stalled result changed");

endmodule

bind contiguous_block_allocator_top cba_checker u_cba_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (req.valid),
  .in_ready    (req.ready),
  .out_valid   (res.valid),
  .out_ready   (res.ready),
  .granted     (res.granted),
  .file_number (res.file_number),
  .end_block   (res.end_block)
);
